@@ rtl/core/aes_pkg.sv @@
// Package for the AES block encryption core: S-box, GF(2^8) helpers, state type.
// Used by aes_key_exp and aes_block_encrypt; no dependencies.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int KEY_WORDS_MAX = 60;
    localparam int KEY_IDX_W     = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd4;

    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } kx_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] b);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

@@ rtl/core/aes_key_exp.sv @@
// Iterative AES key expansion: one schedule word per cycle into a 60-word memory.
// Depends on aes_pkg; read port serves the round unit of aes_block_encrypt.
`timescale 1ns / 1ps
module aes_key_exp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aes_pkg::kx_ctrl_t             ctrl_in,
    input  logic [1:0]                    key_size,
    input  logic [255:0]                  key,
    input  logic [aes_pkg::KEY_IDX_W-1:0] rd_addr,
    output logic [127:0]                  rd_data,
    output logic                          done
);

    // Memory holds groups of four words so one round key is one read.
    localparam int ROWS = aes_pkg::KEY_WORDS_MAX / 4;
    localparam int ROW_W = $clog2(ROWS);

    logic [127:0] mem [ROWS];
    logic [31:0]  win_reg [8];      // last nk words, newest at index 0
    logic [5:0]   idx_reg;
    logic [3:0]   phase_reg;        // i mod nk
    logic [7:0]   rcon_reg;
    logic         run_reg;
    logic [95:0]  row_acc_reg;
    logic [3:0]   nk;
    logic [5:0]   total;
    logic [31:0]  t, w_new, w_back;

    always_comb
    begin
        unique case (key_size)
            aes_pkg::KS_192: nk = 4'd6;
            aes_pkg::KS_256: nk = 4'd8;
            default:         nk = 4'd4;
        endcase
        total = 6'(({2'b00, nk} + 6'd7) << 2);
        w_back = win_reg[3'(nk - 4'd1)];
        t = win_reg[0];
        if (phase_reg == 4'd0)
            t = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && phase_reg == 4'd4)
            t = aes_pkg::sub_word(win_reg[0]);
        w_new = idx_reg < 6'(nk) ? key[255 - 32*idx_reg[2:0] -: 32] : (w_back ^ t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (ctrl_in.start)
        begin
            run_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (run_reg)
        begin
            idx_reg <= idx_reg + 6'd1;
            if (idx_reg == total - 6'd1)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start)
        begin
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (run_reg)
        begin
            for (int k = 7; k > 0; k--)
                win_reg[k] <= win_reg[k-1];
            win_reg[0] <= w_new;
            phase_reg <= (phase_reg == nk - 4'd1) ? 4'd0 : phase_reg + 4'd1;
            if (phase_reg == 4'd0 && idx_reg >= 6'(nk))
                rcon_reg <= aes_pkg::xtime(rcon_reg);
            if (idx_reg[1:0] == 2'd3)
                mem[ROW_W'(idx_reg[5:2])] <= {row_acc_reg, w_new};
            else
                row_acc_reg <= {row_acc_reg[63:0], w_new};
        end
        rd_data <= mem[ROW_W'(rd_addr[5:2])];
    end

    assign done = run_reg && idx_reg == total - 6'd1;

endmodule

@@ rtl/core/aes_block_encrypt.sv @@
// AES-128/192/256 ECB encryption core with on-demand key expansion; needs aes_pkg, aes_key_exp.
// Each of the Nr+1 rounds (Nr = 10, 12 or 14) takes a round key read step and a round step
// on the shared round unit; the result waits in an output register.
// A new block is taken only once the previous result has moved into the output register.
// After a write to the key size or a key register, the next block first waits for key expansion.
// Reset clears control state and all configuration registers to zero.
`timescale 1ns / 1ps
module aes_block_encrypt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [63:0]                    plain_hi,
    input  logic [63:0]                    plain_lo,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [63:0]                    cipher_hi,
    output logic [63:0]                    cipher_lo
);

    aes_pkg::state_t state_reg, state_next;
    aes_pkg::kx_ctrl_t kx_ctrl;

    logic [1:0]   key_size_reg;
    logic [255:0] key_reg;
    logic         sched_ok_reg;
    logic [127:0] st_reg, rk;
    logic [3:0]   rnd_reg;
    logic         phase_reg;     // 0: key read issued, 1: round applied
    logic [3:0]   nr;
    logic         kx_done;
    logic [127:0] sr, mc, round_out;
    logic [127:0] out_reg;
    logic         out_valid_reg;
    logic         out_free;      // output register can take a result at this edge
    logic         last_round;
    logic         out_load;

    // Configuration registers; a write to the key size or a key register marks the schedule stale.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            key_reg      <= '0;
            sched_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aes_pkg::REG_KEY_SIZE: key_size_reg <= cfg_data[1:0];
                    aes_pkg::REG_KEY_0: key_reg[255:192] <= cfg_data;
                    aes_pkg::REG_KEY_1: key_reg[191:128] <= cfg_data;
                    aes_pkg::REG_KEY_2: key_reg[127:64]  <= cfg_data;
                    aes_pkg::REG_KEY_3: key_reg[63:0]    <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= aes_pkg::REG_KEY_3)
                    sched_ok_reg <= 1'b0;
            end
            else if (kx_done)
                sched_ok_reg <= 1'b1;
        end
    end

    always_comb
    begin
        unique case (key_size_reg)
            aes_pkg::KS_192: nr = 4'd12;
            aes_pkg::KS_256: nr = 4'd14;
            default:         nr = 4'd10;
        endcase
    end

    assign kx_ctrl.start = state_reg == aes_pkg::ST_IDLE && in_valid && !sched_ok_reg;

    aes_key_exp u_kx (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (kx_ctrl),
        .key_size (key_size_reg),
        .key      (key_reg),
        .rd_addr  ({rnd_reg, 2'b00}),
        .rd_data  (rk),
        .done     (kx_done)
    );

    // Shared round unit: SubBytes, ShiftRows, MixColumns unless last, key XOR; round 0 XOR only.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[127 - 8*(4*c + r) -: 8] =
                    aes_pkg::sbox(st_reg[127 - 8*(4*((c + r) % 4) + r) -: 8]);
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, all;
            a0 = sr[127 - 32*c -: 8];
            a1 = sr[119 - 32*c -: 8];
            a2 = sr[111 - 32*c -: 8];
            a3 = sr[103 - 32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mc[127 - 32*c -: 32] = {a0 ^ all ^ aes_pkg::xtime(a0 ^ a1),
                                    a1 ^ all ^ aes_pkg::xtime(a1 ^ a2),
                                    a2 ^ all ^ aes_pkg::xtime(a2 ^ a3),
                                    a3 ^ all ^ aes_pkg::xtime(a3 ^ a0)};
        end
        if (rnd_reg == 4'd0)
            round_out = st_reg ^ rk;
        else if (rnd_reg == nr)
            round_out = sr ^ rk;
        else
            round_out = mc ^ rk;
    end

    // The finished block goes straight to the output register when it is free;
    // otherwise it waits in st_reg (DONE) until the pending output beat leaves.
    assign out_free   = !out_valid_reg || out_ready;
    assign last_round = state_reg == aes_pkg::ST_ROUND && phase_reg && rnd_reg == nr;
    assign out_load   = out_free && (last_round || state_reg == aes_pkg::ST_DONE);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aes_pkg::ST_IDLE:
                if (in_valid)
                    state_next = sched_ok_reg ? aes_pkg::ST_ROUND : aes_pkg::ST_EXPAND;
            aes_pkg::ST_EXPAND:
                if (kx_done)
                    state_next = aes_pkg::ST_IDLE;
            aes_pkg::ST_ROUND:
                if (last_round)
                    state_next = out_free ? aes_pkg::ST_IDLE : aes_pkg::ST_DONE;
            aes_pkg::ST_DONE:
                if (out_free)
                    state_next = aes_pkg::ST_IDLE;
            default: state_next = aes_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = state_reg == aes_pkg::ST_IDLE && sched_ok_reg;
        out_valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aes_pkg::ST_IDLE;
            rnd_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != aes_pkg::ST_ROUND)
            begin
                rnd_reg   <= '0;
                phase_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    rnd_reg <= rnd_reg + 4'd1;
            end
        end
    end

    // A stale schedule is rebuilt first (EXPAND), and the input beat is taken
    // only once the schedule is valid.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            st_reg <= {plain_hi, plain_lo};
        else if (state_reg == aes_pkg::ST_ROUND && phase_reg)
            st_reg <= round_out;
    end

    // Output register: holds the ciphertext beat until it is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= (state_reg == aes_pkg::ST_DONE) ? st_reg : round_out;
    end

    assign cipher_hi = out_reg[127:64];
    assign cipher_lo = out_reg[63:0];

endmodule

@@ verif/tb_aes_block_encrypt.sv @@
// Self-checking testbench for aes_block_encrypt: directed vectors, then random blocks
// under several key sizes and keys, checked against a behavioral AES cipher.
// Depends on aes_pkg and the aes_block_encrypt RTL only.
`timescale 1ns / 1ps
module tb_aes_block_encrypt;

    // Key size codes that the package leaves unnamed.
    localparam logic [1:0] KS_128   = 2'd0;
    localparam logic [1:0] KS_SPARE = 2'd3;
    // First and last register indices past the end of the register map.
    localparam logic [aes_pkg::CFG_IDX_W-1:0] REG_NONE_FIRST = 3'd5;
    localparam logic [aes_pkg::CFG_IDX_W-1:0] REG_NONE_LAST  = 3'd7;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam int RANDOM_BLOCKS = 1850;
    localparam int PHASES        = 10;

    typedef struct {
        logic [1:0]   ks;
        logic [63:0]  key [4];
        logic [63:0]  pt_hi;
        logic [63:0]  pt_lo;
        bit           known;
        logic [127:0] ct;
    } vector_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [aes_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [aes_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic out_valid;
    logic out_ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;

    // Shadow of the block's configuration and key schedule.
    logic [7:0]  sub_tab [256];
    logic [1:0]  key_len;
    logic [63:0] key_reg [4];
    logic [31:0] sched [aes_pkg::KEY_WORDS_MAX];
    bit          sched_valid;

    cipher_t cipher_q [$];
    int      errors;
    bit      quiet;
    int      stall_left;

    aes_block_encrypt i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .plain_hi  (plain_hi),
        .plain_lo  (plain_lo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cipher_hi (cipher_hi),
        .cipher_lo (cipher_lo)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // The run must end well inside this time even with every stall at its longest.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = dbl(a);
        end
        return p;
    endfunction

    // The substitution table is derived here from its definition: the multiplicative
    // inverse in GF(2^8) followed by the affine map with constant 0x63.
    function automatic void build_sub_tab();
        logic [7:0] inv;
        logic [7:0] s;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(8'(a), 8'(b)) == 8'h01)
                    inv = 8'(b);
            s = inv;
            for (int k = 1; k <= 4; k++)
                s ^= (inv << k) | (inv >> (8 - k));
            sub_tab[a] = s ^ 8'h63;
        end
    endfunction

    function automatic int key_words();
        if (key_len == aes_pkg::KS_192)
            return 6;
        if (key_len == aes_pkg::KS_256)
            return 8;
        return 4;
    endfunction

    function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk;
        logic [31:0] t;
        logic [7:0] rcon;
        nk = key_words();
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = nk; i < 4 * (nk + 7); i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = sub_bytes32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = dbl(rcon);
            end
            else if (nk == 8 && i % 8 == 4)
                t = sub_bytes32(t);
            sched[i] = sched[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic cipher_t encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0] st [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [7:0] all;
        logic [127:0] blk;
        logic [31:0] w;
        int nr;
        cipher_t res;
        if (!sched_valid)
            expand_schedule();
        nr = key_words() + 6;
        blk = {hi, lo};
        for (int i = 0; i < 16; i++)
            st[i] = blk[127 - 8 * i -: 8];
        for (int rnd = 0; rnd <= nr; rnd++)
        begin
            if (rnd > 0)
            begin
                // Byte substitution and row shift in one pass.
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[c * 4 + r] = sub_tab[st[((c + r) % 4) * 4 + r]];
                st = t;
                if (rnd < nr)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++)
                            col[r] = st[c * 4 + r];
                        all = col[0] ^ col[1] ^ col[2] ^ col[3];
                        for (int r = 0; r < 4; r++)
                            st[c * 4 + r] = col[r] ^ all ^ dbl(col[r] ^ col[(r + 1) % 4]);
                    end
            end
            for (int c = 0; c < 4; c++)
            begin
                w = sched[rnd * 4 + c];
                for (int r = 0; r < 4; r++)
                    st[c * 4 + r] ^= w[31 - 8 * r -: 8];
            end
        end
        for (int i = 0; i < 16; i++)
            blk[127 - 8 * i -: 8] = st[i];
        res.hi = blk[127:64];
        res.lo = blk[63:0];
        return res;
    endfunction

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Register write. The caller lowers cfg_we after its last write, so that
    // back-to-back writes never drop and raise the enable in one time step.
    task automatic reg_write(input logic [aes_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == aes_pkg::REG_KEY_SIZE)
        begin
            key_len = data[1:0];
            sched_valid = 1'b0;
        end
        else if (idx <= aes_pkg::REG_KEY_3)
        begin
            key_reg[idx - aes_pkg::REG_KEY_0] = data;
            sched_valid = 1'b0;
        end
        @(posedge clk);
    endtask

    // Stop sending and wait until every expected ciphertext has come back, then keep
    // waiting so the core is surely back in its idle state.
    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Present one block and wait for the beat to be taken. Valid stays high on
    // return, so a following block with no gap is presented straight away.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input bit known, input logic [127:0] ct);
        int gap;
        cipher_t exp_ct;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        plain_hi <= hi;
        plain_lo <= lo;
        do
            @(posedge clk);
        while (!in_ready);
        exp_ct = encrypt_block(hi, lo);
        if (known)
        begin
            exp_ct.hi = ct[127:64];
            exp_ct.lo = ct[63:0];
        end
        cipher_q = {cipher_q, exp_ct};
    endtask

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 64'h0;
        if (r == 1)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    // Output side: random back-pressure and the check of each ciphertext beat.
    always @(posedge clk)
    begin
        cipher_t exp_ct;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: ciphertext %h_%h with none expected",
                                 $realtime, cipher_hi, cipher_lo);
                end
                else
                begin
                    exp_ct = cipher_q.pop_front();
                    if (cipher_hi !== exp_ct.hi || cipher_lo !== exp_ct.lo)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: ciphertext mismatch, expected %h_%h, got %h_%h",
                                     $realtime, exp_ct.hi, exp_ct.lo, cipher_hi, cipher_lo);
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    // Directed vectors. Known ciphertexts are the published vectors for each key
    // length plus the all-zero key and block straight after reset; the rest are
    // predicted. The spare key size code must behave as a 128-bit key, so its row
    // reuses the 128-bit vector with junk in the unused key registers.
    vector_t directed [11] = '{
        '{KS_128, '{64'h0, 64'h0, 64'h0, 64'h0}, 64'h0, 64'h0,
          1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{KS_128, '{64'h0, 64'h0, 64'h0, 64'h0}, ONES, ONES, 1'b0, 128'h0},
        '{KS_128, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0},
          64'h0011223344556677, 64'h8899aabbccddeeff,
          1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{KS_128, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0},
          64'h0, 64'h0, 1'b0, 128'h0},
        '{KS_128, '{ONES, ONES, 64'h0, 64'h0}, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
          1'b0, 128'h0},
        '{aes_pkg::KS_192,
          '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, 64'h0},
          64'h0011223344556677, 64'h8899aabbccddeeff,
          1'b1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
        '{aes_pkg::KS_192, '{ONES, ONES, ONES, 64'h0}, ONES, ONES, 1'b0, 128'h0},
        '{aes_pkg::KS_256, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                             64'h1011121314151617, 64'h18191a1b1c1d1e1f},
          64'h0011223344556677, 64'h8899aabbccddeeff,
          1'b1, 128'h8ea2b7ca516745bfeafc49904b496089},
        '{aes_pkg::KS_256, '{ONES, ONES, ONES, ONES}, 64'h0, 64'h0, 1'b0, 128'h0},
        '{aes_pkg::KS_256, '{64'h0, 64'h0, 64'h0, 64'h0}, ONES, 64'h0, 1'b0, 128'h0},
        '{KS_SPARE, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, ONES, ONES},
          64'h0011223344556677, 64'h8899aabbccddeeff,
          1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a}
    };

    initial
    begin
        int per_phase;
        bit wrote;
        logic [1:0] ks;
        logic [63:0] hi;
        logic [63:0] lo;
        // Every input starts at a known value; reset is applied once.
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = aes_pkg::REG_KEY_SIZE;
        cfg_data  = 64'h0;
        in_valid  = 1'b0;
        plain_hi  = 64'h0;
        plain_lo  = 64'h0;
        errors    = 0;
        quiet     = 1'b0;
        key_len   = KS_128;
        for (int i = 0; i < 4; i++)
            key_reg[i] = 64'h0;
        sched_valid = 1'b0;
        build_sub_tab();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: only registers that differ from the current setting are
        // written, so the first row runs on the reset values.
        foreach (directed[n])
        begin
            wrote = 1'b0;
            if (directed[n].ks != key_len)
            begin
                drain();
                wrote = 1'b1;
                reg_write(aes_pkg::REG_KEY_SIZE, 64'(directed[n].ks));
            end
            for (int k = 0; k < 4; k++)
                if (directed[n].key[k] != key_reg[k])
                begin
                    if (!wrote)
                        drain();
                    wrote = 1'b1;
                    reg_write(3'(aes_pkg::REG_KEY_0 + k), directed[n].key[k]);
                end
            if (wrote)
                cfg_we <= 1'b0;
            send_block(directed[n].pt_hi, directed[n].pt_lo, directed[n].known, directed[n].ct);
        end

        // Random part: each phase drains, picks a new key size and key, then sends
        // a run of random blocks. The first phases walk all key size codes.
        per_phase = RANDOM_BLOCKS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            quiet = (p % 3 == 2);
            ks = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
            reg_write(aes_pkg::REG_KEY_SIZE, 64'(ks));
            for (int k = 0; k < 4; k++)
                if (p < 2 || $urandom_range(0, 3) != 0)
                    reg_write(3'(aes_pkg::REG_KEY_0 + k), (p == 0) ? ONES : pick_word());
            // Writes past the register map must change nothing.
            if ($urandom_range(0, 1))
                reg_write(3'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)), pick_word());
            cfg_we <= 1'b0;
            for (int n = 0; n < per_phase; n++)
            begin
                hi = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? ONES : 64'h0)
                                                 : {$urandom, $urandom};
                lo = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? ONES : 64'h0)
                                                 : {$urandom, $urandom};
                // Now and then the sender holds off until the core has emptied.
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_block(hi, lo, 1'b0, 128'h0);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (cipher_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/aes_pkg.sv
rtl/core/aes_key_exp.sv
rtl/core/aes_block_encrypt.sv
verif/tb_aes_block_encrypt.sv
